// ===== rtl/core/ssrq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssrq_pkg
// Shared types and constants of the smoothed sample ring queue: request and
// result records, request and register codes, ring geometry and the
// five-point smoothing coefficients with the reciprocal used for the /35.
// ----------------------------------------------------------------------------
package ssrq_pkg;

  localparam int DEPTH      = 256;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int LEN_W      = PTR_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 9;
  localparam int COUNT_W    = 9;
  localparam int CFG_LEN_RESET = 256;
  localparam int STEP_W     = $clog2(LEN_W);

  localparam int HIST_LEN   = 5;
  localparam int WARM_W     = $clog2(HIST_LEN + 1);
  localparam int COEF_OUTER = 3;
  localparam int COEF_INNER = 12;
  localparam int COEF_MID   = 17;
  localparam int DIVISOR    = 35;

  localparam int ACC_W      = SAMPLE_W + 7;
  localparam int MAG_W      = ACC_W - 1;
  localparam int RECIP_SHIFT = MAG_W + 6;
  localparam int RECIP_W    = RECIP_SHIFT - 5;
  localparam longint RECIP_VAL = ((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int PROD_W     = MAG_W + RECIP_W;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_FILTER_ENABLE = 1'b0,
    CFG_QUEUE_LENGTH  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_MOD,
    ST_FLT_WAIT
  } state_e;

  typedef struct packed {
    req_type_e             req_type;
    logic [SAMPLE_W-1:0]   sample;
  } req_t;

  typedef struct packed {
    logic                  pop_valid;
    logic [SAMPLE_W-1:0]   pop_data;
    logic                  sample_stored;
    logic [COUNT_W-1:0]    stored_count;
    logic                  wrapped;
  } rsp_t;

endpackage

// ===== rtl/core/ssrq_ram.sv =====
// ----------------------------------------------------------------------------
// ssrq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ssrq_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ssrq_mod.sv =====
// ----------------------------------------------------------------------------
// ssrq_mod
// Iterative remainder unit: one shifted compare-subtract per cycle, stepping
// from bit LEN_W-1 down to 0, remainder presented with the done pulse.
// ----------------------------------------------------------------------------
module ssrq_mod
  import ssrq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LEN_W-1:0] dividend_i,
  input  logic [LEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [LEN_W-1:0] rem_o
);

  logic               busy_q;
  logic [STEP_W-1:0]  step_q;
  logic [LEN_W-1:0]   rem_q;
  logic [LEN_W-1:0]   div_q;
  logic [2*LEN_W-1:0] trial;
  logic               fits;
  logic [LEN_W-1:0]   rem_d;

  always_comb begin
    trial = {{LEN_W{1'b0}}, div_q} << step_q;
    fits  = {{LEN_W{1'b0}}, rem_q} >= trial;
    rem_d = fits ? (rem_q - trial[LEN_W-1:0]) : rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(LEN_W - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = busy_q && (step_q == '0);
  assign rem_o  = rem_d;

  a_mod_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("remainder unit restarted while busy");

  a_mod_divisor_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> div_q != '0)
    else $error("remainder unit running with zero divisor");

  a_mod_done_result_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rem_o < div_q)
    else $error("remainder not reduced below divisor");

endmodule

// ===== rtl/core/ssrq_smooth.sv =====
// ----------------------------------------------------------------------------
// ssrq_smooth
// Five-sample history with warm-up count and a three-stage smoothing pipe:
// weighted sum, magnitude times reciprocal of 35, signed truncated quotient.
// ----------------------------------------------------------------------------
module ssrq_smooth
  import ssrq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                warm_o,
  output logic                valid_o,
  output logic [SAMPLE_W-1:0] data_o
);

  logic [SAMPLE_W-1:0] hist_q [HIST_LEN];
  logic [WARM_W-1:0]   warm_q;
  logic                go_q;
  logic                acc_v_q;
  logic                prod_v_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [PROD_W-1:0]   prod_q;
  logic                neg_q;

  logic [SAMPLE_W:0]   sum_inner;
  logic [SAMPLE_W:0]   sum_outer;
  logic [MAG_W-1:0]    pos;
  logic [MAG_W-1:0]    negw;
  logic signed [ACC_W-1:0] acc_d;
  logic [MAG_W-1:0]    mag;
  logic [ACC_W-1:0]    acc_neg;
  logic [SAMPLE_W-1:0] quot;

  assign warm_o = (warm_q == WARM_W'(HIST_LEN));

  always_comb begin
    sum_inner = {1'b0, hist_q[1]} + {1'b0, hist_q[3]};
    sum_outer = {1'b0, hist_q[0]} + {1'b0, hist_q[4]};
    pos  = MAG_W'(MAG_W'(sum_inner) * MAG_W'(COEF_INNER))
         + MAG_W'(MAG_W'(hist_q[2]) * MAG_W'(COEF_MID));
    negw = MAG_W'(MAG_W'(sum_outer) * MAG_W'(COEF_OUTER));
    acc_d = $signed({1'b0, pos}) - $signed({1'b0, negw});
  end

  always_comb begin
    acc_neg = ACC_W'(-acc_q);
    mag     = acc_q[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_q[MAG_W-1:0];
    quot    = prod_q[RECIP_SHIFT +: SAMPLE_W];
    data_o  = neg_q ? (SAMPLE_W'(0) - quot) : quot;
    valid_o = prod_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_q[i] <= '0;
      end
      warm_q   <= '0;
      go_q     <= 1'b0;
      acc_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      if (push_i) begin
        for (int i = 0; i < HIST_LEN - 1; i++) begin
          hist_q[i] <= hist_q[i+1];
        end
        hist_q[HIST_LEN-1] <= sample_i;
        if (!warm_o) begin
          warm_q <= warm_q + WARM_W'(1);
        end
      end
      go_q     <= push_i && warm_o;
      acc_v_q  <= go_q;
      prod_v_q <= acc_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_q) begin
      acc_q <= acc_d;
    end
    if (acc_v_q) begin
      prod_q <= PROD_W'(mag) * PROD_W'(RECIP);
      neg_q  <= acc_q[ACC_W-1];
    end
  end

  a_smooth_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_q || acc_v_q || prod_v_q) |-> !push_i)
    else $error("history shifted while a sum is in flight");

  a_smooth_warm_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm_o |=> warm_o)
    else $error("warm-up count dropped");

  a_smooth_one_hot_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({go_q, acc_v_q, prod_v_q}))
    else $error("more than one smoothing request in flight");

endmodule

// ===== rtl/core/smoothed_sample_ring_queue_unit.sv =====
// ----------------------------------------------------------------------------
// smoothed_sample_ring_queue_unit
// Ring queue of 16-bit samples in one synchronous RAM with wrap at the
// configured length, optional five-point smoothing of pushed samples.
// ----------------------------------------------------------------------------
// Answers: push, clear and no-op answer on the cycle after start; a pop answers
//   after the RAM read, or after the iterative remainder when the incremented
//   head reaches the length; a smoothed push answers once the smoothing pipe ends.
// Throughput: busy is low for raw push, clear and no-op (one per cycle); pop and
//   smoothed push hold busy for the RAM read and remainder or the smoothing pipe.
// Reset: pointers, count, wrap flag, history and warm-up clear at once; the RAM
//   is not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module smoothed_sample_ring_queue_unit
  import ssrq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  cfg_idx_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic             wrap_q, wrap_d;
  logic             filter_en_q;
  logic [CFG_W-1:0] qlen_q;
  logic             hit_q, hit_d;
  logic             done_q;
  rsp_t             rsp_q, rsp_d;
  logic             rsp_load;

  logic [LEN_W-1:0] len_act;
  logic             accept;
  logic             is_push, is_pop, is_clear;
  logic [LEN_W-1:0] tail_inc, head_inc;
  logic [PTR_W-1:0] tail_nxt;

  logic                ram_we, ram_re;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  logic                flt_push, flt_warm, flt_valid;
  logic [SAMPLE_W-1:0] flt_data;
  logic                mod_start, mod_done;
  logic [LEN_W-1:0]    mod_rem;

  always_comb begin
    if (qlen_q == '0) begin
      len_act = LEN_W'(1);
    end else if (32'(qlen_q) > DEPTH) begin
      len_act = LEN_W'(DEPTH);
    end else begin
      len_act = LEN_W'(qlen_q);
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy && !start;
  assign accept      = start && !busy;
  assign is_push     = (req_i.req_type == REQ_PUSH);
  assign is_pop      = (req_i.req_type == REQ_POP);
  assign is_clear    = (req_i.req_type == REQ_CLEAR);
  assign tail_inc    = LEN_W'({1'b0, tail_q}) + LEN_W'(1);
  assign head_inc    = LEN_W'({1'b0, head_q}) + LEN_W'(1);
  assign tail_nxt    = (tail_inc >= len_act) ? '0 : tail_inc[PTR_W-1:0];
  assign flt_push    = accept && is_push && filter_en_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_pop) begin
          state_d = ST_POP_RD;
        end else if (flt_push && flt_warm) begin
          state_d = ST_FLT_WAIT;
        end
      end
      ST_POP_RD: begin
        if (hit_q && (head_inc >= len_act)) begin
          state_d = ST_POP_MOD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_POP_MOD: begin
        if (mod_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_FLT_WAIT: begin
        if (flt_valid) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    wrap_d    = wrap_q;
    hit_d     = hit_q;
    ram_we    = 1'b0;
    ram_wdata = req_i.sample;
    ram_re    = 1'b0;
    mod_start = 1'b0;
    rsp_load  = 1'b0;
    rsp_d     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (is_push) begin
            if (!filter_en_q) begin
              ram_we   = 1'b1;
              rsp_load = 1'b1;
              rsp_d.sample_stored = 1'b1;
            end else if (!flt_warm) begin
              rsp_load = 1'b1;
            end
          end else if (is_pop) begin
            hit_d  = (head_q != tail_q);
            ram_re = hit_d;
          end else if (is_clear) begin
            head_d   = '0;
            tail_d   = '0;
            count_d  = '0;
            wrap_d   = 1'b0;
            rsp_load = 1'b1;
          end else begin
            rsp_load = 1'b1;
          end
        end
      end
      ST_POP_RD: begin
        if (!hit_q) begin
          rsp_load = 1'b1;
        end else if (head_inc < len_act) begin
          head_d   = head_inc[PTR_W-1:0];
          rsp_load = 1'b1;
          rsp_d.pop_valid = 1'b1;
          rsp_d.pop_data  = ram_rdata;
        end else begin
          mod_start = 1'b1;
        end
      end
      ST_POP_MOD: begin
        if (mod_done) begin
          head_d   = mod_rem[PTR_W-1:0];
          rsp_load = 1'b1;
          rsp_d.pop_valid = 1'b1;
          rsp_d.pop_data  = ram_rdata;
        end
      end
      ST_FLT_WAIT: begin
        if (flt_valid) begin
          ram_we    = 1'b1;
          ram_wdata = flt_data;
          rsp_load  = 1'b1;
          rsp_d.sample_stored = 1'b1;
        end
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
    if (ram_we) begin
      tail_d = tail_nxt;
      wrap_d = wrap_q | (tail_nxt == '0);
      if (count_q < len_act) begin
        count_d = count_q + LEN_W'(1);
      end
    end
    rsp_d.stored_count = COUNT_W'(count_d);
    rsp_d.wrapped      = wrap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      wrap_q      <= 1'b0;
      hit_q       <= 1'b0;
      done_q      <= 1'b0;
      filter_en_q <= 1'b0;
      qlen_q      <= CFG_W'(CFG_LEN_RESET);
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      wrap_q  <= wrap_d;
      hit_q   <= hit_d;
      done_q  <= rsp_load;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_i)
          CFG_FILTER_ENABLE: filter_en_q <= cfg_data_i[0];
          CFG_QUEUE_LENGTH:  qlen_q      <= cfg_data_i;
          default:           qlen_q      <= qlen_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  ssrq_ram #(
    .Width (SAMPLE_W),
    .Depth (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  ssrq_smooth u_smooth (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (flt_push),
    .sample_i (req_i.sample),
    .warm_o   (flt_warm),
    .valid_o  (flt_valid),
    .data_o   (flt_data)
  );

  ssrq_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (head_inc),
    .divisor_i  (len_act),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  a_no_read_write_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ring read and write in the same cycle");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("stored count above ring depth");

  a_empty_pop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.pop_valid) |-> (rsp_o.pop_data == '0))
    else $error("pop data without a valid pop");

  a_head_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_MOD && mod_done) |=> (LEN_W'({1'b0, head_q}) < $past(len_act)))
    else $error("head not reduced below queue length");

  a_one_result_per_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && rsp_load) |=> !busy)
    else $error("busy request did not finish with its result");

endmodule

// ===== dv/tb_smoothed_sample_ring_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_smoothed_sample_ring_queue_unit
// Self-checking bench for the smoothed sample ring queue. Requests go in on
// the start/busy port in random bursts, and each one is run through a local
// model of the ring, its pointers and the five-point smoother. Every done
// strobe is compared field by field with the oldest predicted response.
// Covers directed corner cases, a full ring at maximum length, and random
// phases with shrinking and growing lengths and filter on and off.
// ----------------------------------------------------------------------------
module tb_smoothed_sample_ring_queue_unit;
  import ssrq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 400;
  localparam int SETTLE_CYC  = 16;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req_i;
  logic             done_o;
  rsp_t             rsp_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  cfg_idx_e         cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  smoothed_sample_ring_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  logic [SAMPLE_W-1:0] ring_mirror [DEPTH];
  bit                  ring_written [DEPTH];
  int                  head_ptr;
  int                  tail_ptr;
  int                  fill_count;
  bit                  wrap_seen;
  logic [SAMPLE_W-1:0] smooth_hist [HIST_LEN];
  int                  warm_cnt;
  bit                  filter_on;
  logic [CFG_W-1:0]    len_reg;

  rsp_t pending_rsp [$];
  int   err_count;
  int   burst_left;
  bit   steady;
  int   idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic rsp_t predict_request(input req_t r);
    rsp_t                rsp;
    int                  len;
    int                  acc;
    int                  quot;
    bit                  write;
    logic [SAMPLE_W-1:0] data;
    rsp = '0;
    len = (len_reg == 0) ? 1 : ((len_reg > DEPTH) ? DEPTH : int'(len_reg));
    data = r.sample;
    case (r.req_type)
      REQ_PUSH: begin
        write = 1'b1;
        if (filter_on) begin
          if (warm_cnt < HIST_LEN) begin
            smooth_hist[warm_cnt] = data;
            warm_cnt++;
            write = 1'b0;
          end else begin
            for (int i = 0; i < HIST_LEN - 1; i++) smooth_hist[i] = smooth_hist[i+1];
            smooth_hist[HIST_LEN-1] = data;
            acc = COEF_INNER * int'(smooth_hist[1]) + COEF_MID * int'(smooth_hist[2])
                + COEF_INNER * int'(smooth_hist[3]) - COEF_OUTER * int'(smooth_hist[0])
                - COEF_OUTER * int'(smooth_hist[4]);
            quot = acc / DIVISOR;
            data = quot[SAMPLE_W-1:0];
          end
        end
        if (write) begin
          ring_mirror[tail_ptr] = data;
          ring_written[tail_ptr] = 1'b1;
          tail_ptr++;
          if (tail_ptr >= len) tail_ptr = 0;
          if (tail_ptr == 0) wrap_seen = 1'b1;
          if (fill_count < len) fill_count++;
          rsp.sample_stored = 1'b1;
        end
      end
      REQ_POP: begin
        if (head_ptr != tail_ptr) begin
          rsp.pop_data = ring_mirror[head_ptr];
          rsp.pop_valid = 1'b1;
          head_ptr = (head_ptr + 1) % len;
        end
      end
      REQ_CLEAR: begin
        head_ptr = 0;
        tail_ptr = 0;
        fill_count = 0;
        wrap_seen = 1'b0;
      end
      default: ;
    endcase
    rsp.stored_count = COUNT_W'(fill_count);
    rsp.wrapped = wrap_seen;
    return rsp;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'(2);
      3: return CFG_W'(DEPTH);
      4: return CFG_W'($urandom_range(DEPTH + 1, 511));
      default: return CFG_W'($urandom_range(3, 40));
    endcase
  endfunction

  task automatic send_request(input req_type_e kind, input logic [SAMPLE_W-1:0] smp);
    req_t r;
    r.req_type = kind;
    r.sample = smp;
    // never pop an entry the RAM has not been written at
    if (kind == REQ_POP && head_ptr != tail_ptr && !ring_written[head_ptr])
      r.req_type = REQ_PUSH;
    pending_rsp.push_back(predict_request(r));
    if (burst_left == 0) begin
      if (!steady) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_FILTER_ENABLE) filter_on = data[0];
    else len_reg = data;
  endtask

  task automatic test_raw_basics();
    send_request(REQ_POP, 16'h1234);
    send_request(REQ_PUSH, 16'h0000);
    send_request(REQ_PUSH, 16'hffff);
    send_request(REQ_POP, 16'hffff);
    send_request(REQ_POP, 16'h0000);
    send_request(REQ_POP, 16'h5555);
    send_request(REQ_NOP, 16'haaaa);
    send_request(REQ_CLEAR, 16'hffff);
  endtask

  task automatic test_filter_warmup();
    logic [SAMPLE_W-1:0] seq [5] = '{16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'hffff};
    write_cfg(CFG_FILTER_ENABLE, 9'h1ff);
    // warm-up fills the history only
    foreach (seq[i]) send_request(REQ_PUSH, seq[i]);
    // second pass ends on a negative sum
    foreach (seq[i]) send_request(REQ_PUSH, seq[i]);
    write_cfg(CFG_FILTER_ENABLE, 9'h000);
  endtask

  task automatic test_length_extremes();
    send_request(REQ_CLEAR, '0);
    write_cfg(CFG_QUEUE_LENGTH, 9'd0);
    send_request(REQ_PUSH, 16'h8000);
    send_request(REQ_POP, '0);
    write_cfg(CFG_QUEUE_LENGTH, 9'd511);
    send_request(REQ_PUSH, 16'h7fff);
  endtask

  task automatic test_length_shrink();
    write_cfg(CFG_QUEUE_LENGTH, CFG_W'(DEPTH));
    send_request(REQ_CLEAR, '0);
    repeat (4) send_request(REQ_PUSH, rand_sample());
    repeat (2) send_request(REQ_POP, '0);
    write_cfg(CFG_QUEUE_LENGTH, 9'd2);
    send_request(REQ_POP, '0);
    send_request(REQ_PUSH, rand_sample());
  endtask

  task automatic test_full_ring();
    write_cfg(CFG_FILTER_ENABLE, 9'h000);
    write_cfg(CFG_QUEUE_LENGTH, CFG_W'(DEPTH));
    send_request(REQ_CLEAR, '0);
    repeat (DEPTH + 4) send_request(REQ_PUSH, rand_sample());
    repeat (40) send_request(REQ_POP, '0);
  endtask

  task automatic test_random_mix();
    int sent;
    int n;
    int pick;
    int clear_pct;
    sent = 0;
    while (sent < 500) begin
      write_cfg(CFG_FILTER_ENABLE, {8'($urandom), 1'($urandom_range(0, 1))});
      write_cfg(CFG_QUEUE_LENGTH, rand_length());
      steady = ($urandom_range(0, 3) == 0);
      clear_pct = $urandom_range(0, 6);
      n = $urandom_range(30, 90);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) send_request(REQ_PUSH, rand_sample());
        else if (pick < 90) send_request(REQ_POP, rand_sample());
        else if (pick < 90 + clear_pct) send_request(REQ_CLEAR, rand_sample());
        else send_request(REQ_NOP, rand_sample());
      end
      sent += n;
    end
    steady = 1'b0;
  endtask

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding");
        err_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        check_field("pop_valid", exp_rsp.pop_valid, rsp_o.pop_valid);
        check_field("pop_data", exp_rsp.pop_data, rsp_o.pop_data);
        check_field("sample_stored", exp_rsp.sample_stored, rsp_o.sample_stored);
        check_field("stored_count", exp_rsp.stored_count, rsp_o.stored_count);
        check_field("wrapped", exp_rsp.wrapped, rsp_o.wrapped);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    err_count = 0;
    burst_left = 0;
    steady = 1'b0;
    head_ptr = 0;
    tail_ptr = 0;
    fill_count = 0;
    wrap_seen = 1'b0;
    warm_cnt = 0;
    filter_on = 1'b0;
    len_reg = CFG_W'(CFG_LEN_RESET);
    foreach (smooth_hist[i]) smooth_hist[i] = '0;
    foreach (ring_mirror[i]) begin
      ring_mirror[i] = '0;
      ring_written[i] = 1'b0;
    end
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_idx_i <= CFG_FILTER_ENABLE;
    cfg_data_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_raw_basics();
    test_filter_warmup();
    test_length_extremes();
    test_length_shrink();
    test_full_ring();
    test_random_mix();

    wait_idle();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ssrq_pkg.sv
rtl/core/ssrq_ram.sv
rtl/core/ssrq_mod.sv
rtl/core/ssrq_smooth.sv
rtl/core/smoothed_sample_ring_queue_unit.sv
dv/tb_smoothed_sample_ring_queue_unit.sv
